// ----- hdl/tsp_pkg.sv -----
package tsp_pkg;

  localparam int TSP_MAX_TERMS   = 16;
  localparam int TSP_FRAC_BITS   = 24;
  localparam int TSP_QUEUE_DEPTH = 2;

  localparam int PHASE_W = 16;
  localparam int CNT_W   = 16;
  localparam int TC_W    = 5;
  localparam int TERM_W  = 6;   // holds a term count up to 63
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_TERM_COUNT  = 1'b1;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 16'd1024;
  localparam logic [TC_W-1:0]  TERM_COUNT_RST  = 5'd8;

  localparam int WORK_BITS = 24;
  localparam int X_SHIFT   = 32 - WORK_BITS;
  localparam int X32_W     = 36;
  localparam int X_W       = 27;
  localparam int X2_W      = 30;
  localparam int MAG_W     = 32;
  localparam int P_W       = MAG_W + X2_W;
  localparam int C_W       = 14;
  localparam int SUM_W     = 40;
  localparam int OUT_W     = 32;

  // 2*pi in Q32, rounded to nearest
  localparam logic [X32_W-1:0] TWO_PI_Q32 = 36'h6487ED511;

  localparam int DIV_W     = 52;
  localparam int DVS_W     = 16;
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [PHASE_W-1:0] idx;
    logic [CNT_W-1:0]   cnt;
    logic [TERM_W-1:0]  nterms;
    logic               skip;
    logic               oor;
  } tsp_job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } tsp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tsp_div_rsp_t;

endpackage

// ----- hdl/tsp_div.sv -----
module tsp_div
  import tsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  tsp_div_req_t req,
  output tsp_div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     num;
  logic [DIV_W-1:0]     quo;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;

  logic [DVS_W:0]       r;
  logic [DIV_W-1:0]     n;
  logic [DIV_RADIX-1:0] qb;

  // several restoring steps per cycle on a narrow remainder
  always_comb begin
    r  = {1'b0, rem};
    n  = num;
    qb = '0;
    for (int j = 0; j < DIV_RADIX; j++) begin
      r = {r[DVS_W-1:0], n[DIV_W-1]};
      n = {n[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r  = r - {1'b0, dvs};
        qb = {qb[DIV_RADIX-2:0], 1'b1};
      end else begin
        qb = {qb[DIV_RADIX-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy & ~req.start & (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
        num  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= n;
        rem <= r[DVS_W-1:0];
        quo <= {quo[DIV_W-DIV_RADIX-1:0], qb};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hdl/tsp_front.sv -----
module tsp_front
  import tsp_pkg::*;
#(
  parameter int MAX_TERMS = TSP_MAX_TERMS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [PHASE_W-1:0]  s_tdata,
  input  logic                q_full,
  output logic                q_push,
  output tsp_job_t            q_job
);

  logic [CNT_W-1:0] point_count;
  logic [TC_W-1:0]  term_count;
  logic             reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
      term_count  <= TERM_COUNT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POINT_COUNT: point_count <= pwdata[CNT_W-1:0];
        REG_TERM_COUNT:  term_count  <= pwdata[TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POINT_COUNT: prdata = DATA_W'(point_count);
      REG_TERM_COUNT:  prdata = DATA_W'(term_count);
      default:         prdata = '0;
    endcase
  end

  // classify: out of range and zero-count items skip evaluation, and the term count is clamped to 1..MAX_TERMS
  always_comb begin
    q_job.idx = s_tdata;
    q_job.cnt = point_count;
    q_job.oor = s_tdata > point_count;
    q_job.skip = q_job.oor | (point_count == '0);
    if (term_count == '0) begin
      q_job.nterms = TERM_W'(1);
    end else if (32'(term_count) > MAX_TERMS) begin
      q_job.nterms = TERM_W'(MAX_TERMS);
    end else begin
      q_job.nterms = TERM_W'(term_count);
    end
  end

  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

endmodule

// ----- hdl/tsp_queue.sv -----
module tsp_queue
  import tsp_pkg::*;
#(
  parameter int DEPTH = TSP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tsp_job_t push_data,
  output logic     full,
  input  logic     pop,
  output tsp_job_t pop_data,
  output logic     empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tsp_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/tsp_back.sv -----
module tsp_back
  import tsp_pkg::*;
#(
  parameter int FRAC_BITS = TSP_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tsp_job_t          q_job,
  output logic              q_pop,
  output tsp_div_req_t      div_req,
  input  tsp_div_rsp_t      div_rsp,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tuser
);

  localparam int UP_SHIFT   = (FRAC_BITS >= WORK_BITS) ? FRAC_BITS - WORK_BITS : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS <  WORK_BITS) ? WORK_BITS - FRAC_BITS : 0;
  localparam int SC_W       = SUM_W + 8;
  localparam logic [SC_W-1:0] SC_RND = SC_W'((64'(1) << DOWN_SHIFT) >> 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_PHASE = 10'b0000000010,
    ST_XDIV  = 10'b0000000100,
    ST_XSQ   = 10'b0000001000,
    ST_X2    = 10'b0000010000,
    ST_TMUL  = 10'b0000100000,
    ST_TRND  = 10'b0001000000,
    ST_TDIV  = 10'b0010000000,
    ST_SCALE = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t                   state;
  tsp_job_t                 job;
  logic                     div_start;
  logic [DIV_W-1:0]         dividend;
  logic [DVS_W-1:0]         divisor;
  logic [X_W-1:0]           x;
  logic [2*X_W-1:0]         sq;
  logic [X2_W-1:0]          x2;
  logic [MAG_W-1:0]         mag;
  logic [P_W-1:0]           p;
  logic [C_W-1:0]           c;
  logic [TERM_W-1:0]        k;
  logic signed [SUM_W-1:0]  sum;
  logic [OUT_W-1:0]         result;
  logic                     out_valid;
  logic [OUT_W-1:0]         out_value;
  logic                     out_oor;

  logic [X32_W-1:0]         x32;
  logic [X_W-1:0]           x_round;
  logic [MAG_W-1:0]         q_mag;
  logic signed [SUM_W-1:0]  q_term;
  logic                     neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [SC_W-1:0]          sc;
  logic [SC_W-1:0]          limit;
  logic [OUT_W-1:0]         sat_mag;

  assign x32     = div_rsp.quotient[X32_W-1:0];
  assign x_round = X_W'((37'(x32) + 37'(1 << (X_SHIFT - 1))) >> X_SHIFT);
  assign q_mag   = div_rsp.quotient[MAG_W-1:0];
  assign q_term  = $signed({{(SUM_W - MAG_W){1'b0}}, q_mag});

  // rescale to the output format: round magnitude half away, then saturate
  always_comb begin
    neg     = sum[SUM_W-1];
    sum_mag = neg ? SUM_W'(-sum) : SUM_W'(sum);
    sc      = ((SC_W'(sum_mag) + SC_RND) >> DOWN_SHIFT) << UP_SHIFT;
    limit   = neg ? SC_W'(64'h8000_0000) : SC_W'(64'h7FFF_FFFF);
    sat_mag = (sc > limit) ? limit[OUT_W-1:0] : sc[OUT_W-1:0];
    result  = neg ? OUT_W'(-sat_mag) : sat_mag;
  end

  assign q_pop            = (state == ST_IDLE) & ~q_empty;
  assign div_req.start    = div_start;
  assign div_req.dividend = dividend;
  assign div_req.divisor  = divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= (state == ST_PHASE) || (state == ST_TRND);
      if ((state == ST_DONE) && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job <= q_job;
            sum <= '0;
            state <= q_job.skip ? ST_SCALE : ST_PHASE;
          end
        end
        ST_PHASE: begin
          dividend  <= DIV_W'(job.idx) * DIV_W'(TWO_PI_Q32) + DIV_W'(job.cnt >> 1);
          divisor   <= DVS_W'(job.cnt);
          state     <= ST_XDIV;
        end
        ST_XDIV: begin
          if (div_rsp.done) begin
            x     <= x_round;
            mag   <= MAG_W'(x_round);
            sum   <= $signed(SUM_W'(x_round));
            state <= ST_XSQ;
          end
        end
        ST_XSQ: begin
          sq    <= (2*X_W)'(x) * (2*X_W)'(x);
          state <= ST_X2;
        end
        ST_X2: begin
          x2    <= X2_W'((sq + ((2*X_W)'(1) << (WORK_BITS - 1))) >> WORK_BITS);
          k     <= TERM_W'(1);
          state <= (job.nterms == TERM_W'(1)) ? ST_SCALE : ST_TMUL;
        end
        ST_TMUL: begin
          p     <= P_W'(mag) * P_W'(x2);
          c     <= C_W'({k, 1'b0}) * C_W'({k, 1'b1});
          state <= ST_TRND;
        end
        ST_TRND: begin
          // divide by c * 2^24 as a shift then a divide by c
          dividend  <= DIV_W'((64'(p) + (64'(c) << (WORK_BITS - 1))) >> WORK_BITS);
          divisor   <= DVS_W'(c);
          state     <= ST_TDIV;
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            mag <= q_mag;
            sum <= k[0] ? sum - q_term : sum + q_term;
            if (k + TERM_W'(1) == job.nterms) begin
              state <= ST_SCALE;
            end else begin
              k     <= k + TERM_W'(1);
              state <= ST_TMUL;
            end
          end
        end
        ST_SCALE: begin
          out_value <= result;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_oor   <= job.oor;
            m_tdata   <= out_value;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_oor;

endmodule

// ----- hdl/taylor_sine_of_phase_index_core.sv -----
// Sine of a phase index by Taylor series. Each index i on the input stream gives one
// result: the sum of the first term_count terms of the sine series at x = 2*pi*i/point_count,
// signed with FRAC_BITS fractional bits (Q8.24 by default) on m_tdata, and a flag on m_tuser
// that marks an index above point_count, whose value is then zero. Items are evaluated one
// at a time in order; a two-entry queue in front lets the input keep flowing while one is
// being worked. The time an evaluated item takes is set by the shared radix-16 serial divider:
// one division for the angle and one per further series term. Out-of-range items and a zero
// point_count skip the series. Registers: point_count at 0x0, term_count at 0x4; the user
// writes them only while idle, which the block itself does not enforce.
module taylor_sine_of_phase_index_core
  import tsp_pkg::*;
#(
  parameter int MAX_TERMS   = TSP_MAX_TERMS,
  parameter int FRAC_BITS   = TSP_FRAC_BITS,
  parameter int QUEUE_DEPTH = TSP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [PHASE_W-1:0] s_tdata,   // [15:0] phase_index
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // [31:0] sine_value
  output logic               m_tuser    // [0] out_of_range
);

  logic         q_full;
  logic         q_push;
  tsp_job_t     q_in;
  logic         q_pop;
  tsp_job_t     q_out;
  logic         q_empty;
  tsp_div_req_t div_req;
  tsp_div_rsp_t div_rsp;

  tsp_front #(
    .MAX_TERMS(MAX_TERMS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in)
  );

  tsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tsp_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (q_out),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- tb/taylor_sine_of_phase_index_core_test.sv -----
module taylor_sine_of_phase_index_core_test
  import tsp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD        = 8;
  localparam int SEGMENTS          = 9;
  localparam int ITEMS_PER_SEGMENT = 200;
  localparam int STALL_LIMIT       = 5000;
  localparam int TAIL_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 4;
  localparam int SERIES_FRAC       = 24;    // working format of the series, Q.24

  localparam longint unsigned TWO_PI_Q32_REF = 64'h6487ED511;

  localparam logic [ADDR_W-1:0] ADDR_POINT_COUNT = ADDR_W'({REG_POINT_COUNT, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_TERM_COUNT  = ADDR_W'({REG_TERM_COUNT, 2'b00});

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             oor;
  } sine_result_t;

  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_PREDICT,
    ROW_FIXED
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t         kind;
    logic [CNT_W-1:0]   pc;
    logic [TC_W-1:0]    tc;
    logic [PHASE_W-1:0] phase;
    logic [OUT_W-1:0]   value;
    logic               oor;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;

  // first rows run with the register values left by reset
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_FIXED,   16'd0,     5'd0,  16'd0,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1024,   32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd1025,   32'd0, 1'b1},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd65535,  32'd0, 1'b1},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd256,    32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd512,    32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd768,    32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1023,   32'd0, 1'b0},
    // zero point count: only index zero is in range
    '{ROW_CONFIG,  16'd0,     5'd8,  16'd0,      32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd0,      32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd1,      32'd0, 1'b1},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd65535,  32'd0, 1'b1},
    // zero terms acts as one term
    '{ROW_CONFIG,  16'd4,     5'd0,  16'd0,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd4,      32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd5,      32'd0, 1'b1},
    // term count above the maximum is clamped
    '{ROW_CONFIG,  16'd4,     5'd31, 16'd0,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd3,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd4,      32'd0, 1'b0},
    '{ROW_CONFIG,  16'd65535, 5'd16, 16'd0,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd65535,  32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'h8000,   32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'h5555,   32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'hAAAA,   32'd0, 1'b0},
    '{ROW_CONFIG,  16'd1,     5'd1,  16'd0,      32'd0, 1'b0},
    '{ROW_PREDICT, 16'd0,     5'd0,  16'd1,      32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd0,      32'd0, 1'b0},
    '{ROW_FIXED,   16'd0,     5'd0,  16'd2,      32'd0, 1'b1}
  };

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [ADDR_W-1:0]  paddr    = '0;
  logic [DATA_W-1:0]  pwdata   = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [PHASE_W-1:0] s_tdata  = '0;   // [15:0] phase_index
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;         // [31:0] sine_value
  logic               m_tuser;         // [0] out_of_range

  logic [CNT_W-1:0] cfg_point_count = POINT_COUNT_RST;
  logic [TC_W-1:0]  cfg_term_count  = TERM_COUNT_RST;

  sine_result_t sine_results_q [$];
  sine_result_t got_want;
  int           errors       = 0;
  int           src_idle_pct = 0;
  int           rcv_idle_pct = 0;
  int           quiet_cycles = 0;

  taylor_sine_of_phase_index_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Taylor sum in Q.24, magnitudes with alternating sign, then rescale and saturate
  function automatic sine_result_t sine_of_phase(input logic [PHASE_W-1:0] phase,
                                                 input logic [CNT_W-1:0]   count,
                                                 input logic [TC_W-1:0]    terms);
    sine_result_t    res;
    longint unsigned angle_q32, x, x_sq, mag, den, m, lim;
    longint          acc;
    int              n, shift_dn;
    bit              neg;
    res.value = '0;
    res.oor   = phase > count;
    if (res.oor || count == 0) return res;
    n = (terms == 0) ? 1 : (terms > TSP_MAX_TERMS) ? TSP_MAX_TERMS : int'(terms);
    angle_q32 = (64'(phase) * TWO_PI_Q32_REF + 64'(count / 2)) / 64'(count);
    x    = (angle_q32 + (64'd1 << (31 - SERIES_FRAC))) >> (32 - SERIES_FRAC);
    x_sq = (x * x + (64'd1 << (SERIES_FRAC - 1))) >> SERIES_FRAC;
    mag  = x;
    acc  = longint'(x);
    for (int k = 1; k < n; k++) begin
      den = 64'((2 * k) * (2 * k + 1)) << SERIES_FRAC;
      mag = (mag * x_sq + den / 2) / den;
      if (k % 2 == 1) acc -= longint'(mag);
      else acc += longint'(mag);
    end
    neg = acc < 0;
    m = neg ? 64'(-acc) : 64'(acc);
    shift_dn = SERIES_FRAC - TSP_FRAC_BITS;
    if (shift_dn > 0) m = (m + (64'd1 << (shift_dn - 1))) >> shift_dn;
    else m = m << (-shift_dn);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (m > lim) m = lim;
    res.value = neg ? OUT_W'(-m) : OUT_W'(m);
    return res;
  endfunction

  // mostly in-range indexes, with the edges, one past the count and raw noise mixed in
  function automatic logic [PHASE_W-1:0] pick_phase(input logic [CNT_W-1:0] count);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 78) return PHASE_W'($urandom_range(count, 0));
    if (roll < 84) return roll[0] ? count : '0;
    if (roll < 90) return count + 1'b1;
    return PHASE_W'($urandom);
  endfunction

  task automatic send_phase(input logic [PHASE_W-1:0] phase, input sine_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= phase;
    do @(posedge clk); while (!s_tready);
    sine_results_q.push_back(want);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sine_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register 0x%0h expected %h actual %h", $time, addr, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of each write carry junk that the register must drop
  task automatic load_config(input logic [CNT_W-1:0] pc, input logic [TC_W-1:0] tc);
    wait_drained();
    apb_write(ADDR_POINT_COUNT, {16'($urandom), pc});
    apb_write(ADDR_TERM_COUNT, {27'($urandom), tc});
    check_reg(ADDR_POINT_COUNT, DATA_W'(pc));
    check_reg(ADDR_TERM_COUNT, DATA_W'(tc));
    cfg_point_count = pc;
    cfg_term_count  = tc;
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sine_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, value %h oor %b", $time, m_tdata, m_tuser);
      end else begin
        got_want = sine_results_q.pop_front();
        if (m_tdata !== got_want.value) begin
          errors++;
          $display("%0t: sine_value expected %h actual %h", $time, got_want.value, m_tdata);
        end
        if (m_tuser !== got_want.oor) begin
          errors++;
          $display("%0t: out_of_range expected %b actual %b", $time, got_want.oor, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CNT_W-1:0]   pc;
    logic [TC_W-1:0]    tc;
    logic [PHASE_W-1:0] phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(ADDR_POINT_COUNT, DATA_W'(POINT_COUNT_RST));
    check_reg(ADDR_TERM_COUNT, DATA_W'(TERM_COUNT_RST));

    src_idle_pct = 22;
    rcv_idle_pct = 59;
    foreach (PLAN[i]) begin
      case (PLAN[i].kind)
        ROW_CONFIG: begin
          load_config(PLAN[i].pc, PLAN[i].tc);
        end
        ROW_PREDICT: begin
          send_phase(PLAN[i].phase,
                     sine_of_phase(PLAN[i].phase, cfg_point_count, cfg_term_count));
        end
        default: begin
          send_phase(PLAN[i].phase, '{value: PLAN[i].value, oor: PLAN[i].oor});
        end
      endcase
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pc = $urandom_range(1) ? CNT_W'($urandom_range(64, 2)) : CNT_W'($urandom_range(65535, 2));
      tc = TC_W'($urandom_range(31, 0));
      case (seg)
        0: begin pc = 16'd65535; tc = 5'd16; end
        1: begin pc = 16'd1;     tc = 5'd1;  end
        3: begin pc = 16'd0;     tc = 5'd31; end
        4: begin pc = 16'd360;   tc = 5'd0;  end
        7: begin pc = 16'd7;     tc = 5'd17; end
        default: ;
      endcase
      load_config(pc, tc);
      if (seg < 3) begin
        src_idle_pct = 22;
        rcv_idle_pct = 59;
      end else if (seg < 6) begin
        src_idle_pct = 59;
        rcv_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      repeat (ITEMS_PER_SEGMENT) begin
        phase = pick_phase(cfg_point_count);
        send_phase(phase, sine_of_phase(phase, cfg_point_count, cfg_term_count));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && sine_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
